@@ hw/rtl/ssw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  localparam int unsigned MAX_SERVOS = 16;
  localparam logic [15:0] GOAL_ADDRESS = 16'd116;
  localparam logic [15:0] TORQUE_ADDRESS = 16'd64;
  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [11:0] POS_MAX = 12'd4095;

  // configuration register indexes
  localparam logic [1:0] CFG_SERVO_COUNT = 2'd0;
  localparam logic [1:0] CFG_OUTPUT_COUNT = 2'd1;
  localparam logic [1:0] CFG_BASE_ID = 2'd2;

  // byte positions within a request's burst
  localparam logic [4:0] POS_HEAD_LEN = 5'd12;
  localparam logic [4:0] POS_LEN_POS = 5'd5;
  localparam logic [4:0] POS_ID_POS = 5'd12;
  localparam logic [4:0] POS_LO_POS = 5'd13;
  localparam logic [4:0] POS_HI_POS = 5'd14;
  localparam logic [4:0] POS_DATA_END = 5'd16;
  localparam logic [4:0] POS_CRC_LO = 5'd17;
  localparam logic [4:0] POS_CRC_HI = 5'd18;
  localparam logic [4:0] TQ_HEAD_LEN = 5'd11;
  localparam logic [4:0] TQ_ID_POS = 5'd4;
  localparam logic [4:0] TQ_VAL_POS = 5'd10;
  localparam logic [4:0] TQ_CRC_LO = 5'd11;
  localparam logic [4:0] TQ_CRC_HI = 5'd12;

  // sync-write head; the length low byte is patched in
  localparam logic [7:0] POS_HEAD [12] = '{
    8'hFF, 8'hFF, 8'hFD, 8'h00, 8'hFE, 8'h00, 8'h00, 8'h83,
    GOAL_ADDRESS[7:0], GOAL_ADDRESS[15:8], 8'h04, 8'h00
  };

  // single write; id and value bytes are patched in
  localparam logic [7:0] TQ_HEAD [12] = '{
    8'hFF, 8'hFF, 8'hFD, 8'h00, 8'h00, 8'h06, 8'h00, 8'h03,
    TORQUE_ADDRESS[7:0], TORQUE_ADDRESS[15:8], 8'h00, 8'h00
  };

  typedef struct packed {
    logic [4:0] servo_count;
    logic [4:0] output_count;
    logic [7:0] base_id;
  } cfg_t;

  typedef struct packed {
    logic        is_torque;
    logic        head;
    logic        close;
    logic [7:0]  len_lo;
    logic [7:0]  id;
    logic [11:0] pos;
    logic        torque_on;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ssw_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface ssw_item_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [15:0] position;
  logic [3:0]         servo_offset;
  logic               torque_on;

  modport source(output valid, operation, position, servo_offset, torque_on, input ready);
  modport sink(input valid, operation, position, servo_offset, torque_on, output ready);
endinterface

interface ssw_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       packet_end;

  modport source(output valid, tx_byte, packet_end, input ready);
  modport sink(input valid, tx_byte, packet_end, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/servo_sync_write_packet_framer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Payload                                     Handshake
// in_i     in   operation, position, servo_offset, torque_on valid/ready
// out_o    out  tx_byte, packet_end                          valid/ready
// cfg      in   cfg_index_i, cfg_data_i                      cfg_we_i
//
// One byte leaves per cycle while out_o.ready stays high; the back-end byte sequencer sets the
// rate. A position request emits 5 bytes, plus 12 for a packet head and 2 for the
// closing CRC; a torque request emits 13. Requests enter at one per cycle while the
// two-entry queue has room.
// Reset: asynchronous, active low; registers to 1/16/1, packet state cleared.
// Output stall backs up into the queue and then holds in_i.ready low.

module servo_sync_write_packet_framer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  ssw_item_if.sink        in_i,
  ssw_byte_if.source      out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  ssw_pkg::cfg_t      cfg_q;
  ssw_pkg::job_t      push_data, pop_data;
  ssw_pkg::q_status_t q_status;
  logic               push, pop;

  // config registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.servo_count <= 5'd1;
      cfg_q.output_count <= 5'd16;
      cfg_q.base_id <= 8'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ssw_pkg::CFG_SERVO_COUNT: cfg_q.servo_count <= cfg_data_i[4:0];
        ssw_pkg::CFG_OUTPUT_COUNT: cfg_q.output_count <= cfg_data_i[4:0];
        ssw_pkg::CFG_BASE_ID: cfg_q.base_id <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: classify the request, track the slot of the open packet
  ssw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cfg_i       (cfg_q),
    .q_full_i    (q_status.full),
    .push_data_o (push_data),
    .push_o      (push)
  );

  // decouples request intake from byte emission
  ssw_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .status_o    (q_status)
  );

  // back: byte sequencer with running CRC and output register
  ssw_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_data_i  (pop_data),
    .q_empty_i (q_status.empty),
    .pop_o     (pop),
    .out_o     (out_o)
  );

  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !q_status.empty)
    else $error("accepted request missing from queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_status.empty)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

@@ hw/rtl/ssw_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssw_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  ssw_item_if.sink           in_i,
  input  wire ssw_pkg::cfg_t cfg_i,
  input  wire logic          q_full_i,
  output ssw_pkg::job_t      push_data_o,
  output logic               push_o
);

  logic [3:0] slot_q, slot_d;
  logic [4:0] n_c;
  logic       close_c;
  logic [11:0] pos_c;

  assign in_i.ready = !q_full_i;
  assign push_o = in_i.valid && !q_full_i;

  always_comb begin
    // N = min(servo_count, output_count, MAX_SERVOS), at least 1
    n_c = cfg_i.servo_count;
    if (n_c > cfg_i.output_count) n_c = cfg_i.output_count;
    if (n_c > 5'(ssw_pkg::MAX_SERVOS)) n_c = 5'(ssw_pkg::MAX_SERVOS);
    if (n_c == 5'd0) n_c = 5'd1;

    close_c = ({1'b0, slot_q} + 5'd1) >= n_c;

    if (in_i.position[15]) pos_c = 12'd0;
    else if (in_i.position[14:12] != 3'd0) pos_c = ssw_pkg::POS_MAX;
    else pos_c = in_i.position[11:0];

    push_data_o.is_torque = in_i.operation;
    push_data_o.head = (slot_q == 4'd0);
    push_data_o.close = close_c;
    push_data_o.len_lo = 8'd7 + ({3'b000, n_c} * 8'd5);
    push_data_o.id = in_i.operation ? (cfg_i.base_id + {4'h0, in_i.servo_offset})
                                    : (cfg_i.base_id + {4'h0, slot_q});
    push_data_o.pos = pos_c;
    push_data_o.torque_on = in_i.torque_on;

    slot_d = slot_q;
    if (push_o && !in_i.operation) begin
      slot_d = close_c ? 4'd0 : slot_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= 4'd0;
    end else begin
      slot_q <= slot_d;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssw_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssw_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ssw_pkg::job_t  push_data_i,
  input  wire logic           pop_i,
  output ssw_pkg::job_t       pop_data_o,
  output ssw_pkg::q_status_t  status_o
);

  ssw_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign status_o.full = (count_q == 2'd2);
  assign status_o.empty = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/ssw_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ssw_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire ssw_pkg::job_t q_data_i,
  input  wire logic          q_empty_i,
  output logic               pop_o,
  ssw_byte_if.source         out_o
);

  ssw_pkg::job_t job_q;
  logic        busy_q, busy_d;
  logic [4:0]  idx_q;
  logic [15:0] crc_q, crc_d, pos_crc_q, pos_crc_next;
  logic        out_valid_q;
  logic [7:0]  out_byte_q, byte_c;
  logic        out_end_q;
  logic        adv, last, is_crc, is_hi;
  logic [4:0]  start_idx;

  assign out_o.valid = out_valid_q;
  assign out_o.tx_byte = out_byte_q;
  assign out_o.packet_end = out_end_q;

  always_comb begin
    byte_c = 8'h00;
    is_crc = 1'b0;
    is_hi = 1'b0;
    if (job_q.is_torque) begin
      if (idx_q < ssw_pkg::TQ_HEAD_LEN) byte_c = ssw_pkg::TQ_HEAD[idx_q[3:0]];
      if (idx_q == ssw_pkg::TQ_ID_POS) byte_c = job_q.id;
      if (idx_q == ssw_pkg::TQ_VAL_POS) byte_c = {7'd0, job_q.torque_on};
      if (idx_q == ssw_pkg::TQ_CRC_LO) begin
        byte_c = crc_q[7:0];
        is_crc = 1'b1;
      end
      if (idx_q == ssw_pkg::TQ_CRC_HI) begin
        byte_c = crc_q[15:8];
        is_crc = 1'b1;
        is_hi = 1'b1;
      end
      last = (idx_q == ssw_pkg::TQ_CRC_HI);
    end else begin
      if (idx_q < ssw_pkg::POS_HEAD_LEN) byte_c = ssw_pkg::POS_HEAD[idx_q[3:0]];
      if (idx_q == ssw_pkg::POS_LEN_POS) byte_c = job_q.len_lo;
      if (idx_q == ssw_pkg::POS_ID_POS) byte_c = job_q.id;
      if (idx_q == ssw_pkg::POS_LO_POS) byte_c = job_q.pos[7:0];
      if (idx_q == ssw_pkg::POS_HI_POS) byte_c = {4'h0, job_q.pos[11:8]};
      if (idx_q == ssw_pkg::POS_CRC_LO) begin
        byte_c = crc_q[7:0];
        is_crc = 1'b1;
      end
      if (idx_q == ssw_pkg::POS_CRC_HI) begin
        byte_c = crc_q[15:8];
        is_crc = 1'b1;
        is_hi = 1'b1;
      end
      last = job_q.close ? (idx_q == ssw_pkg::POS_CRC_HI) : (idx_q == ssw_pkg::POS_DATA_END);
    end

    crc_d = is_crc ? crc_q : ssw_pkg::crc16_byte(crc_q, byte_c);
    adv = busy_q && (!out_valid_q || out_o.ready);
    // forward the open packet's CRC into a job that follows straight on
    pos_crc_next = (adv && last && !job_q.is_torque) ? crc_d : pos_crc_q;
    pop_o = !q_empty_i && (!busy_q || (adv && last));
    start_idx = (q_data_i.is_torque || q_data_i.head) ? 5'd0 : ssw_pkg::POS_ID_POS;

    busy_d = busy_q;
    if (pop_o) busy_d = 1'b1;
    else if (adv && last) busy_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      out_valid_q <= 1'b0;
      pos_crc_q <= 16'h0000;
    end else begin
      busy_q <= busy_d;
      pos_crc_q <= pos_crc_next;
      if (adv) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_byte_q <= byte_c;
      out_end_q <= is_hi;
    end
    if (pop_o) begin
      job_q <= q_data_i;
      idx_q <= start_idx;
      crc_q <= (q_data_i.is_torque || q_data_i.head) ? 16'h0000 : pos_crc_next;
    end else if (adv) begin
      idx_q <= idx_q + 5'd1;
      crc_q <= crc_d;
    end
  end

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

  // request operation codes
  localparam logic OP_GOAL   = 1'b0;
  localparam logic OP_TORQUE = 1'b1;

  // register index with no register behind it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [15:0] BUS_CRC_POLY = 16'h8005;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_CYCLES = 400;

  typedef struct packed {
    logic               operation;
    logic signed [15:0] position;
    logic [3:0]         servo_offset;
    logic               torque_on;
  } servo_req_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       packet_end;
  } bus_byte_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [1:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  ssw_item_if in_if ();
  ssw_byte_if out_if ();

  servo_sync_write_packet_framer DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // requests waiting to be offered, and bus bytes still awaited
  servo_req_t pend_req_q[$];
  bus_byte_t  bus_byte_q[$];
  servo_req_t req_on_bus;

  // mirror of the framer's registers and packet state
  logic [4:0]  m_servo_count;
  logic [4:0]  m_output_count;
  logic [7:0]  m_base_id;
  logic [15:0] m_open_crc;   // CRC of the position packet in progress
  logic [3:0]  m_slot;       // next slot of that packet
  logic [15:0] frame_crc;    // CRC of the bytes predicted so far for one packet

  int tx_idle_pct;
  int rx_idle_pct;
  int fail_count;
  int req_count;
  int torque_count;
  int byte_count;
  int packet_count;
  int cfg_count;

  // long receiver hold-off, timed in its own process
  bit stall_arm;
  bit stall_done;
  int stall_left;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Generous fixed limit on the whole run.
  initial begin
    #4000000;
    $display("Verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------

  // CRC-16, poly 0x8005, MSB first, one data bit at a time
  function automatic logic [15:0] bus_crc_step(logic [15:0] crc, logic [7:0] data);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb  = crc[15] ^ data[i];
      crc = {crc[14:0], 1'b0};
      if (fb) crc = crc ^ BUS_CRC_POLY;
    end
    return crc;
  endfunction

  function automatic void await_byte(logic [7:0] data);
    bus_byte_q.push_back('{tx_byte: data, packet_end: 1'b0});
    frame_crc = bus_crc_step(frame_crc, data);
  endfunction

  // CRC goes out low byte first; the high byte ends the packet
  function automatic void await_crc();
    bus_byte_q.push_back('{tx_byte: frame_crc[7:0], packet_end: 1'b0});
    bus_byte_q.push_back('{tx_byte: frame_crc[15:8], packet_end: 1'b1});
  endfunction

  // servos per sync-write: both counts capped, never below one
  function automatic int servos_per_packet();
    int n;
    n = m_servo_count;
    if (n > m_output_count) n = m_output_count;
    if (n > ssw_pkg::MAX_SERVOS) n = ssw_pkg::MAX_SERVOS;
    if (n < 1) n = 1;
    return n;
  endfunction

  function automatic void frame_request(servo_req_t r);
    int          n;
    int          goal;
    logic [11:0] pos;
    logic [15:0] len;
    if (r.operation == OP_TORQUE) begin
      // self-contained single write; the open sync-write is left alone
      frame_crc = '0;
      await_byte(8'hFF);
      await_byte(8'hFF);
      await_byte(8'hFD);
      await_byte(8'h00);
      await_byte(m_base_id + 8'(r.servo_offset));
      await_byte(8'h06);
      await_byte(8'h00);
      await_byte(8'h03);
      await_byte(ssw_pkg::TORQUE_ADDRESS[7:0]);
      await_byte(ssw_pkg::TORQUE_ADDRESS[15:8]);
      await_byte({7'd0, r.torque_on});
      await_crc();
    end else begin
      n    = servos_per_packet();
      goal = $signed(r.position);
      if (goal < 0) pos = '0;
      else if (goal > 4095) pos = 12'd4095;
      else pos = goal[11:0];
      frame_crc = m_open_crc;
      if (m_slot == 4'd0) begin
        len       = 16'(7 + 5 * n);
        frame_crc = '0;
        await_byte(8'hFF);
        await_byte(8'hFF);
        await_byte(8'hFD);
        await_byte(8'h00);
        await_byte(8'hFE);
        await_byte(len[7:0]);
        await_byte(len[15:8]);
        await_byte(8'h83);
        await_byte(ssw_pkg::GOAL_ADDRESS[7:0]);
        await_byte(ssw_pkg::GOAL_ADDRESS[15:8]);
        await_byte(8'h04);
        await_byte(8'h00);
      end
      await_byte(m_base_id + 8'(m_slot));
      await_byte(pos[7:0]);
      await_byte({4'd0, pos[11:8]});
      await_byte(8'h00);
      await_byte(8'h00);
      // closes as soon as the slot reaches the current count, even if it shrank
      if (int'(m_slot) + 1 >= n) begin
        await_crc();
        m_slot     = '0;
        m_open_crc = '0;
      end else begin
        m_slot     = m_slot + 4'd1;
        m_open_crc = frame_crc;
      end
    end
  endfunction

  // ---------------------------------------------------------------------
  // Driver: offers queued requests, predicts on acceptance
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        frame_request(req_on_bus);
        req_count++;
        if (req_on_bus.operation == OP_TORQUE) torque_count++;
      end
      // a request that is still waiting stays on the bus untouched
      if (!in_if.valid || in_if.ready) begin
        if (pend_req_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          req_on_bus = pend_req_q.pop_front();
          in_if.valid        <= 1'b1;
          in_if.operation    <= req_on_bus.operation;
          in_if.position     <= req_on_bus.position;
          in_if.servo_offset <= req_on_bus.servo_offset;
          in_if.torque_on    <= req_on_bus.torque_on;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each byte, drives ready
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin : byte_monitor
    bus_byte_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        byte_count++;
        if (out_if.packet_end) packet_count++;
        if (bus_byte_q.size() == 0) begin
          $error("byte %02h with nothing awaited", out_if.tx_byte);
          fail_count++;
        end else begin
          want = bus_byte_q.pop_front();
          if (out_if.tx_byte !== want.tx_byte) begin
            $error("tx_byte: expected %02h, got %02h", want.tx_byte, out_if.tx_byte);
            fail_count++;
          end
          if (out_if.packet_end !== want.packet_end) begin
            $error("packet_end: expected %0b, got %0b", want.packet_end,
                   out_if.packet_end);
            fail_count++;
          end
        end
      end
      out_if.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Hold-off: once armed, the receiver stays deaf until stall_left runs out, so the
  // framer's queue fills and in_i.ready drops while requests keep coming.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      stall_left <= 0;
      stall_done <= 1'b0;
    end else if (stall_arm && !stall_done) begin
      stall_left <= STALL_CYCLES;
      stall_done <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // registers are only written while the framer is idle
  task automatic cfg_write(logic [1:0] idx, logic [7:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      ssw_pkg::CFG_SERVO_COUNT:  m_servo_count  = data[4:0];
      ssw_pkg::CFG_OUTPUT_COUNT: m_output_count = data[4:0];
      ssw_pkg::CFG_BASE_ID:      m_base_id      = data;
      default: ;
    endcase
    cfg_count++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_goal(int goal);
    servo_req_t r;
    r.operation    = OP_GOAL;
    r.position     = 16'(goal);
    r.servo_offset = 4'($urandom);
    r.torque_on    = 1'($urandom);
    pend_req_q.push_back(r);
  endtask

  task automatic push_torque(logic [3:0] offset, logic on);
    servo_req_t r;
    r.operation    = OP_TORQUE;
    r.position     = 16'($urandom);
    r.servo_offset = offset;
    r.torque_on    = on;
    pend_req_q.push_back(r);
  endtask

  // mostly goals, with torque writes breaking into open packets
  task automatic push_random_request();
    int goal;
    case ($urandom_range(0, 7))
      0:       goal = $signed(16'($urandom));
      1:       goal = -$urandom_range(1, 32768);
      2:       goal = 4095 + $urandom_range(1, 28672);
      3:       goal = ($urandom_range(0, 1) == 1) ? 4095 : 0;
      default: goal = $urandom_range(0, 4095);
    endcase
    if ($urandom_range(0, 99) < 15) push_torque(4'($urandom), 1'($urandom));
    else push_goal(goal);
  endtask

  function automatic logic [7:0] random_count();
    case ($urandom_range(0, 4))
      0:       return 8'($urandom_range(1, 4));
      1:       return 8'($urandom_range(1, 16));
      2:       return 8'($urandom);                       // 0 and >16 clamp
      3:       return ($urandom_range(0, 1) == 1) ? 8'd16 : 8'd1;
      default: return 8'($urandom_range(1, 6));
    endcase
  endfunction

  // Registers left unwritten keep their value, so packets often stay open
  // across a phase and see their count change underneath them.
  task automatic random_config();
    if ($urandom_range(0, 99) < 70) cfg_write(ssw_pkg::CFG_SERVO_COUNT, random_count());
    if ($urandom_range(0, 99) < 50) cfg_write(ssw_pkg::CFG_OUTPUT_COUNT, random_count());
    if ($urandom_range(0, 99) < 60) cfg_write(ssw_pkg::CFG_BASE_ID, 8'($urandom));
    if ($urandom_range(0, 99) < 5) cfg_write(CFG_UNUSED, 8'($urandom));
  endtask

  // wait until every request has gone in and every byte has come out
  task automatic drain();
    while (pend_req_q.size() != 0 || in_if.valid || bus_byte_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int mode_reqs;
    int batch;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_index_i        = ssw_pkg::CFG_SERVO_COUNT;
    cfg_data_i         = '0;
    in_if.valid        = 1'b0;
    in_if.operation    = OP_GOAL;
    in_if.position     = '0;
    in_if.servo_offset = '0;
    in_if.torque_on    = 1'b0;
    out_if.ready       = 1'b0;
    stall_arm          = 1'b0;
    fail_count         = 0;
    req_count          = 0;
    torque_count       = 0;
    byte_count         = 0;
    packet_count       = 0;
    cfg_count          = 0;
    tx_idle_pct        = 30;
    rx_idle_pct        = 61;

    // reset state of the framer: counts 1 / 16, base id 1, no open packet
    m_servo_count  = 5'd1;
    m_output_count = 5'd16;
    m_base_id      = 8'd1;
    m_open_crc     = '0;
    m_slot         = '0;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: one-servo packets at reset settings, goal saturation edges,
    // torque writes at both offsets and values.
    push_goal(-32768);
    push_goal(32767);
    push_goal(0);
    push_goal(4095);
    push_goal(4096);
    push_goal(-1);
    push_torque(4'd15, 1'b1);
    push_torque(4'd0, 1'b0);
    drain();

    // three-servo packet with ids wrapping past 255, torque write inside it,
    // then a fresh packet left open
    cfg_write(ssw_pkg::CFG_SERVO_COUNT, 8'd3);
    cfg_write(ssw_pkg::CFG_OUTPUT_COUNT, 8'd31);
    cfg_write(ssw_pkg::CFG_BASE_ID, 8'd255);
    @(negedge clk_i);
    push_goal(100);
    push_torque(4'd1, 1'b1);
    push_goal(2048);
    push_goal(3000);
    push_goal(7);
    drain();

    // count cut to zero (clamps to one) with a packet open: next goal closes it;
    // a write to the unused index must change nothing
    cfg_write(ssw_pkg::CFG_SERVO_COUNT, 8'd0);
    cfg_write(CFG_UNUSED, 8'hFF);
    @(negedge clk_i);
    push_goal(1234);
    drain();

    // output count of zero caps everything to one servo
    cfg_write(ssw_pkg::CFG_SERVO_COUNT, 8'd31);
    cfg_write(ssw_pkg::CFG_OUTPUT_COUNT, 8'd0);
    @(negedge clk_i);
    push_goal(1);
    drain();

    // Random part in three idling modes; the last one also carries the
    // long receiver hold-off with the sender never pausing.
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0:       begin tx_idle_pct = 30; rx_idle_pct = 61; end
        1:       begin tx_idle_pct = 61; rx_idle_pct = 30; end
        default: begin tx_idle_pct = 0;  rx_idle_pct = 0;  end
      endcase
      mode_reqs = 0;
      while (mode_reqs < 165) begin
        if (mode_reqs == 0) begin
          // widest packet: both counts past the limit
          cfg_write(ssw_pkg::CFG_SERVO_COUNT, 8'd31);
          cfg_write(ssw_pkg::CFG_OUTPUT_COUNT, 8'd31);
          cfg_write(ssw_pkg::CFG_BASE_ID, 8'($urandom));
        end else begin
          random_config();
        end
        @(negedge clk_i);
        if (mode == 2 && mode_reqs == 0) stall_arm = 1'b1;
        batch = $urandom_range(12, 50);
        repeat (batch) push_random_request();
        mode_reqs += batch;
        drain();
      end
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Run covered %0d requests (%0d torque writes), %0d bus bytes, %0d packets,",
             req_count, torque_count, byte_count, packet_count);
    $display("%0d register writes, three idling modes and one long receiver stall.",
             cfg_count);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
